// ----- rtl/dcr_pkg.sv -----
// Shared types, codes and the resolution table of the display control register window.
package dcr_pkg;

    localparam int NUM_MODES   = 11;
    localparam int SCR_W       = 11;
    localparam int WORD_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 88;

    localparam logic [6:0] ACCESS_BYTES = 7'd4;
    localparam logic       ACC_WRITE    = 1'b1;

    // Supported resolutions, searched from the first entry up
    localparam logic [SCR_W-1:0] MODE_W [NUM_MODES] = '{
        11'd10, 11'd100, 11'd160, 11'd160, 11'd320, 11'd320,
        11'd640, 11'd640, 11'd800, 11'd1024, 11'd1280
    };
    localparam logic [SCR_W-1:0] MODE_H [NUM_MODES] = '{
        11'd10, 11'd100, 11'd100, 11'd120, 11'd200, 11'd240,
        11'd400, 11'd480, 11'd600, 11'd768, 11'd1024
    };

    localparam logic [SCR_W-1:0] RST_SCR_W = 11'd640;
    localparam logic [SCR_W-1:0] RST_SCR_H = 11'd400;
    localparam logic [15:0]      RST_MAX_W = 16'd1280;
    localparam logic [15:0]      RST_MAX_H = 16'd1024;

    // Register window word indexes
    localparam logic [WORD_W-1:0] WORD_MODE     = 10'd0;
    localparam logic [WORD_W-1:0] WORD_WIDTH    = 10'd1;
    localparam logic [WORD_W-1:0] WORD_HEIGHT   = 10'd2;
    localparam logic [WORD_W-1:0] WORD_CMD_OFS  = 10'd3;
    localparam logic [WORD_W-1:0] WORD_DUMP     = 10'd4;
    localparam logic [WORD_W-1:0] WORD_DUMP_KEY = 10'd5;
    localparam logic [WORD_W-1:0] WORD_MAX_W    = 10'd6;
    localparam logic [WORD_W-1:0] WORD_MAX_H    = 10'd7;
    localparam logic [WORD_W-1:0] WORD_RSVD     = 10'd8;
    localparam logic [WORD_W-1:0] WORD_FB_ID    = 10'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_W   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_H   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_ID   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ALIGN = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_EXACT       = 2'd0,
        RES_ADJUSTED    = 2'd1,
        RES_UNSUPPORTED = 2'd2
    } t_res_status;

    typedef struct packed {
        logic             found;
        logic             exact;
        logic [SCR_W-1:0] width;
        logic [SCR_W-1:0] height;
    } t_snap;

    typedef struct packed {
        logic        mode;
        logic [11:0] address;
        logic [6:0]  access_size;
        logic [31:0] write_data;
    } t_request;

    typedef struct packed {
        logic [31:0] dump_key_out;
        logic        dump_timestamp;
        logic [7:0]  dump_stream;
        logic        dump_event;
        logic        redraw_event;
        logic        erase_screen;
        logic        resize_event;
        t_res_status resolution_status;
        t_status     status;
        logic [31:0] read_data;
    } t_result;

endpackage

// ----- rtl/display_control_registers_unit.sv -----
// Top level of the display control register window: request register, decode, result register.
//
// Slave stream s_axis carries one bus access per word (tuser = access kind,
// 1 write / 0 read); master stream m_axis returns exactly one result word per
// access, in order. Configuration registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data, one per cycle, and the user must write them only
// while no access is in flight; the block does not enforce it. An accepted
// access sits in the request register until the result register is free or
// is being taken; it is then decoded and its result is registered in the
// result register, which drives m_axis_tvalid and m_axis_tdata. Throughput
// is one access per cycle while the receiver does not stall; the state
// written by one access is visible to the access right behind it, as all
// state updates share the result register's clock edge.
// When the receiver stalls, the result register holds and the request
// register still takes one more word; s_axis_tready drops only when both
// are full and m_axis_tready is low. Synchronous reset empties both stages
// and loads the reset values: screen 640x400, limits 1280x1024, all other
// registers zero.
module display_control_registers_unit
    import dcr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [11:0] address, [18:12] access_size, [50:19] write_data
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] read_data, [33:32] status, [35:34] resolution_status,
    // [36] resize_event, [37] erase_screen, [38] redraw_event, [39] dump_event,
    // [47:40] dump_stream, [48] dump_timestamp, [80:49] dump_key_out
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic             r_disp_en;
    logic [15:0]      r_max_w;
    logic [15:0]      r_max_h;
    logic [7:0]       r_fb_id;

    logic [31:0]      r_req_w,   n_req_w;
    logic [31:0]      r_req_h,   n_req_h;
    logic [SCR_W-1:0] r_scr_w,   n_scr_w;
    logic [SCR_W-1:0] r_scr_h,   n_scr_h;
    logic [31:0]      r_cmd_ofs, n_cmd_ofs;
    logic [31:0]      r_dump_key, n_dump_key;

    t_request         r_in;
    logic             r_in_vld;
    t_result          r_out, n_out;
    logic             r_out_vld;

    logic             w_adv;
    logic [WORD_W-1:0] w_word;
    t_snap            w_snap;

    // Advance the request into the result register when that slot frees up
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out};
    assign w_word        = r_in.address[11:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_en <= 1'b0;
            r_max_w   <= RST_MAX_W;
            r_max_h   <= RST_MAX_H;
            r_fb_id   <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DISP_EN: r_disp_en <= i_cfg_data[0];
                CFG_MAX_W:   r_max_w   <= i_cfg_data;
                CFG_MAX_H:   r_max_h   <= i_cfg_data;
                CFG_FB_ID:   r_fb_id   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.mode        <= s_axis_tuser;
            r_in.address     <= s_axis_tdata[11:0];
            r_in.access_size <= s_axis_tdata[18:12];
            r_in.write_data  <= s_axis_tdata[50:19];
        end
    end

    dcr_mode_snap u_snap (
        .i_req_w (r_req_w),
        .i_req_h (r_req_h),
        .o_snap  (w_snap)
    );

    always_comb begin
        n_out      = '0;
        n_req_w    = r_req_w;
        n_req_h    = r_req_h;
        n_scr_w    = r_scr_w;
        n_scr_h    = r_scr_h;
        n_cmd_ofs  = r_cmd_ofs;
        n_dump_key = r_dump_key;

        if (r_in.address[1:0] != 2'd0 || r_in.access_size != ACCESS_BYTES) begin
            n_out.status = ST_ALIGN;
        end else if (r_in.mode == ACC_WRITE) begin
            unique case (w_word)
                WORD_MODE: begin
                    if (w_snap.found) begin
                        n_out.resolution_status = w_snap.exact ? RES_EXACT : RES_ADJUSTED;
                        n_scr_w            = w_snap.width;
                        n_scr_h            = w_snap.height;
                        n_out.resize_event = 1'b1;
                        n_out.erase_screen = (r_in.write_data != 32'd0);
                    end else begin
                        n_out.resolution_status = RES_UNSUPPORTED;
                    end
                end
                WORD_WIDTH:  n_req_w = r_in.write_data;
                WORD_HEIGHT: n_req_h = r_in.write_data;
                WORD_CMD_OFS: begin
                    n_cmd_ofs          = r_in.write_data;
                    n_out.redraw_event = 1'b1;
                end
                WORD_DUMP: begin
                    n_out.dump_event     = 1'b1;
                    n_out.dump_stream    = r_in.write_data[7:0];
                    n_out.dump_timestamp = r_in.write_data[8];
                    n_out.dump_key_out   = r_dump_key;
                end
                WORD_DUMP_KEY: n_dump_key = r_in.write_data;
                default: n_out.status = ST_RANGE;
            endcase
        end else begin
            unique case (w_word) inside
                WORD_MODE:     n_out.read_data = {31'd0, r_disp_en};
                WORD_WIDTH:    n_out.read_data = {21'd0, r_scr_w};
                WORD_HEIGHT:   n_out.read_data = {21'd0, r_scr_h};
                WORD_CMD_OFS:  n_out.read_data = r_cmd_ofs;
                WORD_DUMP_KEY: n_out.read_data = r_dump_key;
                WORD_MAX_W:    n_out.read_data = {16'd0, r_max_w};
                WORD_MAX_H:    n_out.read_data = {16'd0, r_max_h};
                WORD_FB_ID:    n_out.read_data = {24'd0, r_fb_id};
                WORD_DUMP,
                WORD_RSVD:     n_out.read_data = 32'd0;
                default:       n_out.status    = ST_RANGE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_w    <= 32'd0;
            r_req_h    <= 32'd0;
            r_scr_w    <= RST_SCR_W;
            r_scr_h    <= RST_SCR_H;
            r_cmd_ofs  <= 32'd0;
            r_dump_key <= 32'd0;
        end else if (w_adv) begin
            r_req_w    <= n_req_w;
            r_req_h    <= n_req_h;
            r_scr_w    <= n_scr_w;
            r_scr_h    <= n_scr_h;
            r_cmd_ofs  <= n_cmd_ofs;
            r_dump_key <= n_dump_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_scr_w) && $stable(r_scr_h) && $stable(r_dump_key))
        else $error("screen state changed without an access");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_vld && r_out_vld && !m_axis_tready)
        else $error("input stalled with a free stage");

    a_resize_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.resize_event |->
            r_out.status == ST_OK && r_out.resolution_status != RES_UNSUPPORTED)
        else $error("resize reported on a rejected or unsupported commit");
`endif

endmodule

// ----- rtl/dcr_mode_snap.sv -----
// Snaps a requested width and height to the smallest covering supported resolution.
module dcr_mode_snap
    import dcr_pkg::*;
(
    input  logic [31:0] i_req_w,
    input  logic [31:0] i_req_h,
    output t_snap       o_snap
);

    // Walk from the largest entry down so the first covering entry wins
    always_comb begin
        o_snap = '0;
        for (int i = NUM_MODES - 1; i >= 0; i--) begin
            if (i_req_w <= 32'(MODE_W[i]) && i_req_h <= 32'(MODE_H[i])) begin
                o_snap.found  = 1'b1;
                o_snap.exact  = (i_req_w == 32'(MODE_W[i])) && (i_req_h == 32'(MODE_H[i]));
                o_snap.width  = MODE_W[i];
                o_snap.height = MODE_H[i];
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the display control register window, scoreboard and stream drivers.
module testbench
    import dcr_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 130;

    // Resolutions in search order
    localparam int unsigned SNAP_W [NUM_MODES] = '{
        10, 100, 160, 160, 320, 320, 640, 640, 800, 1024, 1280
    };
    localparam int unsigned SNAP_H [NUM_MODES] = '{
        10, 100, 100, 120, 200, 240, 400, 480, 600, 768, 1024
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [11:0] address, [18:12] access_size, [50:19] write_data
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [0] mode
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [31:0] read_data, [33:32] status, [35:34] resolution_status,
    // [36] resize_event, [37] erase_screen, [38] redraw_event, [39] dump_event,
    // [47:40] dump_stream, [48] dump_timestamp, [80:49] dump_key_out
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int src_idle_pct;
    int sink_stall_pct;
    int idle_cycles;

    class display_regs_scoreboard;
        t_result     pending_q[$];
        int          errors;
        logic        disp_en;
        logic [15:0] max_w;
        logic [15:0] max_h;
        logic [7:0]  fb_id;
        logic [31:0] req_w;
        logic [31:0] req_h;
        logic [10:0] scr_w;
        logic [10:0] scr_h;
        logic [31:0] cmd_ofs;
        logic [31:0] dump_key;

        function new();
            errors   = 0;
            disp_en  = 1'b0;
            max_w    = 16'd1280;
            max_h    = 16'd1024;
            fb_id    = 8'd0;
            req_w    = '0;
            req_h    = '0;
            scr_w    = 11'd640;
            scr_h    = 11'd400;
            cmd_ofs  = '0;
            dump_key = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DISP_EN: disp_en = val[0];
                CFG_MAX_W:   max_w   = val;
                CFG_MAX_H:   max_h   = val;
                CFG_FB_ID:   fb_id   = val[7:0];
                default: ;
            endcase
        endfunction

        // Predict the result of one accepted access and update the register state
        function void note_access(t_request r);
            t_result     e;
            logic [9:0]  word;
            int          hit;
            e    = '0;
            word = r.address[11:2];
            hit  = -1;
            e.status            = ST_OK;
            e.resolution_status = RES_EXACT;
            if (r.address[1:0] != 2'b00 || r.access_size != ACCESS_BYTES) begin
                e.status = ST_ALIGN;
            end else if (r.mode == ACC_WRITE) begin
                if (word > WORD_DUMP_KEY) begin
                    e.status = ST_RANGE;
                end else begin
                    case (word)
                        WORD_MODE: begin
                            for (int i = 0; i < NUM_MODES; i++) begin
                                if (hit < 0 && req_w <= SNAP_W[i] && req_h <= SNAP_H[i])
                                    hit = i;
                            end
                            if (hit < 0) begin
                                e.resolution_status = RES_UNSUPPORTED;
                            end else begin
                                if (SNAP_W[hit] != req_w || SNAP_H[hit] != req_h)
                                    e.resolution_status = RES_ADJUSTED;
                                scr_w          = 11'(SNAP_W[hit]);
                                scr_h          = 11'(SNAP_H[hit]);
                                e.resize_event = 1'b1;
                                e.erase_screen = (r.write_data != 0);
                            end
                        end
                        WORD_WIDTH:  req_w = r.write_data;
                        WORD_HEIGHT: req_h = r.write_data;
                        WORD_CMD_OFS: begin
                            cmd_ofs        = r.write_data;
                            e.redraw_event = 1'b1;
                        end
                        WORD_DUMP: begin
                            e.dump_event     = 1'b1;
                            e.dump_stream    = r.write_data[7:0];
                            e.dump_timestamp = r.write_data[8];
                            e.dump_key_out   = dump_key;
                        end
                        default: dump_key = r.write_data;
                    endcase
                end
            end else begin
                case (word) inside
                    WORD_MODE:     e.read_data = {31'b0, disp_en};
                    WORD_WIDTH:    e.read_data = {21'b0, scr_w};
                    WORD_HEIGHT:   e.read_data = {21'b0, scr_h};
                    WORD_CMD_OFS:  e.read_data = cmd_ofs;
                    WORD_DUMP_KEY: e.read_data = dump_key;
                    WORD_MAX_W:    e.read_data = {16'b0, max_w};
                    WORD_MAX_H:    e.read_data = {16'b0, max_h};
                    WORD_FB_ID:    e.read_data = {24'b0, fb_id};
                    WORD_DUMP, WORD_RSVD: e.read_data = '0;
                    default:       e.status = ST_RANGE;
                endcase
            end
            pending_q.insert(pending_q.size(), e);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result a);
            t_result e;
            if (pending_q.size() == 0) begin
                $display("%0t ns: result word with nothing pending, actual %h", $time, a);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            cmp("read_data",         e.read_data,               a.read_data);
            cmp("status",            32'(e.status),             32'(a.status));
            cmp("resolution_status", 32'(e.resolution_status),  32'(a.resolution_status));
            cmp("resize_event",      32'(e.resize_event),       32'(a.resize_event));
            cmp("erase_screen",      32'(e.erase_screen),       32'(a.erase_screen));
            cmp("redraw_event",      32'(e.redraw_event),       32'(a.redraw_event));
            cmp("dump_event",        32'(e.dump_event),         32'(a.dump_event));
            cmp("dump_stream",       32'(e.dump_stream),        32'(a.dump_stream));
            cmp("dump_timestamp",    32'(e.dump_timestamp),     32'(a.dump_timestamp));
            cmp("dump_key_out",      e.dump_key_out,            a.dump_key_out);
        endfunction
    endclass

    display_regs_scoreboard sb = new();

    display_control_registers_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Check result words and randomize the receiver's ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata[80:0]));
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_request mk_req(logic m, logic [11:0] a, logic [6:0] s, logic [31:0] d);
        t_request r;
        r.mode        = m;
        r.address     = a;
        r.access_size = s;
        r.write_data  = d;
        return r;
    endfunction

    // Pick a requested dimension: on a table entry, just off one, or anywhere
    function automatic logic [31:0] pick_dim(bit is_w);
        int unsigned base;
        int          idx;
        idx  = $urandom_range(NUM_MODES - 1);
        base = is_w ? SNAP_W[idx] : SNAP_H[idx];
        case ($urandom_range(4))
            0: return base;
            1: return base - 1;
            2: return base + 1;
            3: return $urandom_range(2047);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_access(t_request r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r.write_data, r.access_size, r.address};
        s_axis_tuser  <= r.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_access(r);
    endtask

    task automatic reg_access(logic m, logic [9:0] word, logic [31:0] d);
        push_access(mk_req(m, {word, 2'b00}, ACCESS_BYTES, d));
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_register(idx, val);
    endtask

    // Hold until every pending result has drained, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_traffic(int n);
        int         cnt;
        int         pick;
        logic [9:0] word;
        cnt = 0;
        while (cnt < n) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                // full mode change: request size, commit, read back
                reg_access(ACC_WRITE, WORD_WIDTH, pick_dim(1));
                reg_access(ACC_WRITE, WORD_HEIGHT, pick_dim(0));
                reg_access(ACC_WRITE, WORD_MODE, $urandom_range(1) ? 32'd0 : $urandom);
                reg_access(~ACC_WRITE, WORD_WIDTH, $urandom);
                reg_access(~ACC_WRITE, WORD_HEIGHT, $urandom);
                cnt += 5;
            end else if (pick < 80) begin
                word = ($urandom_range(19) == 0) ? 10'($urandom_range(1023))
                                                 : 10'($urandom_range(11));
                reg_access(1'($urandom_range(1)), word, $urandom);
                cnt++;
            end else begin
                push_access(mk_req(1'($urandom_range(1)), 12'($urandom_range(4095)),
                                   7'($urandom_range(64)), $urandom));
                cnt++;
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every read word, rejects, snapping corners, events
        for (int w = 0; w <= 10; w++)
            reg_access(~ACC_WRITE, 10'(w), 32'hFFFF_FFFF);
        reg_access(~ACC_WRITE, 10'h3FF, '0);
        push_access(mk_req(ACC_WRITE, 12'hFFF, ACCESS_BYTES, 32'h1));
        push_access(mk_req(~ACC_WRITE, 12'h001, ACCESS_BYTES, '0));
        push_access(mk_req(ACC_WRITE, '0, 7'd0, 32'h1));
        push_access(mk_req(~ACC_WRITE, 12'h004, 7'd64, '0));
        push_access(mk_req(ACC_WRITE, 12'h00C, 7'd63, 32'h5));
        reg_access(ACC_WRITE, WORD_WIDTH, 32'd1280);
        reg_access(ACC_WRITE, WORD_HEIGHT, 32'd1024);
        reg_access(ACC_WRITE, WORD_MODE, 32'd0);
        reg_access(ACC_WRITE, WORD_WIDTH, 32'd1281);
        reg_access(ACC_WRITE, WORD_MODE, 32'd1);
        reg_access(ACC_WRITE, WORD_WIDTH, 32'd5);
        reg_access(ACC_WRITE, WORD_HEIGHT, 32'd7);
        reg_access(ACC_WRITE, WORD_MODE, 32'hFFFF_FFFF);
        reg_access(ACC_WRITE, WORD_CMD_OFS, 32'hFFFF_FFFF);
        reg_access(ACC_WRITE, WORD_DUMP_KEY, 32'hA5C3_0F96);
        reg_access(ACC_WRITE, WORD_DUMP, 32'h0000_01FF);
        reg_access(ACC_WRITE, WORD_MAX_W, 32'h1234_5678);
        reg_access(ACC_WRITE, 10'h3FF, 32'h1);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    cfg_write(CFG_DISP_EN, '0);
                    cfg_write(CFG_MAX_W, '0);
                    cfg_write(CFG_MAX_H, '0);
                    cfg_write(CFG_FB_ID, '0);
                end
                1: begin
                    cfg_write(CFG_DISP_EN, '1);
                    cfg_write(CFG_MAX_W, '1);
                    cfg_write(CFG_MAX_H, '1);
                    cfg_write(CFG_FB_ID, '1);
                end
                default: begin
                    cfg_write(CFG_DISP_EN, 16'($urandom_range(65535)));
                    cfg_write(CFG_MAX_W, 16'($urandom_range(65535)));
                    cfg_write(CFG_MAX_H, 16'($urandom_range(65535)));
                    cfg_write(CFG_FB_ID, 16'($urandom_range(65535)));
                end
            endcase
            i_cfg_we <= 1'b0;
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 66; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 66; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            random_traffic(PHASE_ITEMS);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
